// File: design/sync_length_frame_crc16_parser_macros.svh
// assertion macros shared by the parser rtl
// all macros sample on clk_i and are disabled while rst_ni is low
`ifndef SYNC_LENGTH_FRAME_CRC16_PARSER_MACROS_SVH
`define SYNC_LENGTH_FRAME_CRC16_PARSER_MACROS_SVH

// same-cycle implication
`define SLFC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SLFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/slfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slfc_pkg
// Types, constants and the crc update shared by the frame parser files.
// ----------------------------------------------------------------------------
package slfc_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned LenW      = 16;
  localparam int unsigned CrcW      = 16;
  localparam int unsigned EventW    = 2;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [CrcW-1:0] CrcInit = 16'hFFFF;
  localparam logic [CrcW-1:0] CrcPoly = 16'hA001;

  localparam logic [ByteW-1:0] SyncFirstRst  = 8'hAA;
  localparam logic [ByteW-1:0] SyncSecondRst = 8'h55;
  localparam logic [LenW-1:0]  MaxLenRst     = 16'd256;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SYNC_FIRST  = 2'd0,
    REG_SYNC_SECOND = 2'd1,
    REG_MAX_LEN     = 2'd2,
    REG_UNUSED      = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    PH_SYNC0   = 3'd0,
    PH_SYNC1   = 3'd1,
    PH_LEN_LO  = 3'd2,
    PH_LEN_HI  = 3'd3,
    PH_CMD     = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_CRC_LO  = 3'd6,
    PH_CRC_HI  = 3'd7
  } phase_e;

  typedef enum logic [EventW-1:0] {
    EV_NONE   = 2'd0,
    EV_READY  = 2'd1,
    EV_BADLEN = 2'd2,
    EV_BADCRC = 2'd3
  } event_e;

  // crc-16/modbus, one byte, reflected, unrolled over the eight bit steps
  function automatic logic [CrcW-1:0] crc_update(input logic [CrcW-1:0] crc,
                                                 input logic [ByteW-1:0] b);
    logic [CrcW-1:0] c;
    c = crc ^ {{(CrcW-ByteW){1'b0}}, b};
    for (int k = 0; k < ByteW; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// File: design/slfc_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slfc_ifs
// Valid/ready channel interfaces for the byte input, the result output and
// the configuration write port.
// ----------------------------------------------------------------------------
interface slfc_in_if;
  logic                      valid;
  logic                      ready;
  logic [slfc_pkg::ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface slfc_out_if;
  logic                        valid;
  logic                        ready;
  logic [slfc_pkg::EventW-1:0] event_res;
  logic                        is_payload;
  logic [slfc_pkg::LenW-1:0]   payload_position;
  logic [slfc_pkg::ByteW-1:0]  frame_command;
  logic [slfc_pkg::LenW-1:0]   frame_length;

  modport source (output valid, output event_res, output is_payload,
                  output payload_position, output frame_command,
                  output frame_length, input ready);
  modport sink   (input valid, input event_res, input is_payload,
                  input payload_position, input frame_command,
                  input frame_length, output ready);
endinterface

interface slfc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [slfc_pkg::CfgIdxW-1:0]  index;
  logic [slfc_pkg::CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/sync_length_frame_crc16_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_length_frame_crc16_parser
// Sync/length framed packet parser with a running crc-16/modbus check; one
// result per received byte.
// ----------------------------------------------------------------------------
// result: registered; result valid rises in the cycle after the byte transfer
// throughput: 1 byte per cycle while the result is taken; the phase fsm and the unrolled byte-wide crc
//   update sit between the frame registers and the result register
// reset: rst_ni async low; all but the result payload registers return to their defaults, fsm to sync hunt
`include "sync_length_frame_crc16_parser_macros.svh"

module sync_length_frame_crc16_parser (
  input  logic       clk_i,
  input  logic       rst_ni,
  slfc_in_if.sink    rx_i,
  slfc_cfg_if.sink   cfg_i,
  slfc_out_if.source res_o
);

  // configuration
  logic [slfc_pkg::ByteW-1:0] sync_first_q, sync_second_q;
  logic [slfc_pkg::LenW-1:0]  max_len_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q  <= slfc_pkg::SyncFirstRst;
      sync_second_q <= slfc_pkg::SyncSecondRst;
      max_len_q     <= slfc_pkg::MaxLenRst;
    end else if (cfg_i.valid) begin
      unique case (slfc_pkg::cfg_reg_e'(cfg_i.index))
        slfc_pkg::REG_SYNC_FIRST:  sync_first_q  <= cfg_i.data[slfc_pkg::ByteW-1:0];
        slfc_pkg::REG_SYNC_SECOND: sync_second_q <= cfg_i.data[slfc_pkg::ByteW-1:0];
        slfc_pkg::REG_MAX_LEN:     max_len_q     <= cfg_i.data[slfc_pkg::LenW-1:0];
        default: ;
      endcase
    end
  end

  // frame state
  slfc_pkg::phase_e            phase_q, phase_d;
  logic [slfc_pkg::LenW-1:0]   length_q, length_d;
  logic [slfc_pkg::ByteW-1:0]  command_q, command_d;
  logic [slfc_pkg::LenW-1:0]   count_q, count_d;
  logic [slfc_pkg::CrcW-1:0]   crc_q, crc_d;
  logic [slfc_pkg::CrcW-1:0]   check_q, check_d;

  slfc_pkg::event_e            evt_d;
  logic                        isp_d;
  logic [slfc_pkg::LenW-1:0]   pos_d;

  logic                        in_xfer;
  logic [slfc_pkg::ByteW-1:0]  b;
  logic [slfc_pkg::LenW-1:0]   len_full;
  logic [slfc_pkg::LenW-1:0]   count_inc;
  logic [slfc_pkg::CrcW-1:0]   check_full;
  logic [slfc_pkg::CrcW-1:0]   crc_in, crc_next;

  // output register
  logic                        res_valid_q;

  assign rx_i.ready = !res_valid_q || res_o.ready;
  assign in_xfer    = rx_i.valid && rx_i.ready;
  assign b          = rx_i.rx_byte;

  assign len_full   = {b, length_q[slfc_pkg::ByteW-1:0]};
  assign check_full = {b, check_q[slfc_pkg::ByteW-1:0]};
  assign count_inc  = count_q + slfc_pkg::LenW'(1);
  assign crc_in     = (phase_q == slfc_pkg::PH_CMD) ? slfc_pkg::CrcInit : crc_q;
  assign crc_next   = slfc_pkg::crc_update(crc_in, b);

  always_comb begin
    phase_d   = phase_q;
    length_d  = length_q;
    command_d = command_q;
    count_d   = count_q;
    crc_d     = crc_q;
    check_d   = check_q;
    evt_d     = slfc_pkg::EV_NONE;
    isp_d     = 1'b0;
    pos_d     = '0;
    unique case (phase_q)
      slfc_pkg::PH_SYNC0: begin
        if (b == sync_first_q) begin
          phase_d = slfc_pkg::PH_SYNC1;
        end
      end
      slfc_pkg::PH_SYNC1: begin
        phase_d = (b == sync_second_q) ? slfc_pkg::PH_LEN_LO : slfc_pkg::PH_SYNC0;
      end
      slfc_pkg::PH_LEN_LO: begin
        length_d = {{(slfc_pkg::LenW-slfc_pkg::ByteW){1'b0}}, b};
        phase_d  = slfc_pkg::PH_LEN_HI;
      end
      slfc_pkg::PH_LEN_HI: begin
        if (len_full > max_len_q) begin
          phase_d   = slfc_pkg::PH_SYNC0;
          length_d  = '0;
          command_d = '0;
          count_d   = '0;
          crc_d     = slfc_pkg::CrcInit;
          check_d   = '0;
          evt_d     = slfc_pkg::EV_BADLEN;
        end else begin
          length_d = len_full;
          phase_d  = slfc_pkg::PH_CMD;
        end
      end
      slfc_pkg::PH_CMD: begin
        command_d = b;
        count_d   = '0;
        crc_d     = crc_next;
        phase_d   = (length_q == '0) ? slfc_pkg::PH_CRC_LO : slfc_pkg::PH_PAYLOAD;
      end
      slfc_pkg::PH_PAYLOAD: begin
        isp_d   = 1'b1;
        pos_d   = count_q;
        crc_d   = crc_next;
        count_d = count_inc;
        if (count_inc == length_q) begin
          phase_d = slfc_pkg::PH_CRC_LO;
        end
      end
      slfc_pkg::PH_CRC_LO: begin
        check_d = {{(slfc_pkg::CrcW-slfc_pkg::ByteW){1'b0}}, b};
        phase_d = slfc_pkg::PH_CRC_HI;
      end
      slfc_pkg::PH_CRC_HI: begin
        if (check_full == crc_q) begin
          check_d = check_full;
          phase_d = slfc_pkg::PH_SYNC0;
          evt_d   = slfc_pkg::EV_READY;
        end else begin
          phase_d   = slfc_pkg::PH_SYNC0;
          length_d  = '0;
          command_d = '0;
          count_d   = '0;
          crc_d     = slfc_pkg::CrcInit;
          check_d   = '0;
          evt_d     = slfc_pkg::EV_BADCRC;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= slfc_pkg::PH_SYNC0;
      length_q  <= '0;
      command_q <= '0;
      count_q   <= '0;
      crc_q     <= slfc_pkg::CrcInit;
      check_q   <= '0;
    end else if (in_xfer) begin
      phase_q   <= phase_d;
      length_q  <= length_d;
      command_q <= command_d;
      count_q   <= count_d;
      crc_q     <= crc_d;
      check_q   <= check_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (in_xfer) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      res_o.event_res        <= evt_d;
      res_o.is_payload       <= isp_d;
      res_o.payload_position <= pos_d;
      res_o.frame_command    <= command_d;
      res_o.frame_length     <= length_d;
    end
  end

  assign res_o.valid = res_valid_q;

  // checks
  `SLFC_ASSERT_NEXT(a_xfer_gives_result, in_xfer, res_valid_q, "byte transfer without result")
  `SLFC_ASSERT_SAME(a_payload_no_event, res_valid_q && res_o.is_payload, res_o.event_res == slfc_pkg::EV_NONE, "payload byte carries an event")
  `SLFC_ASSERT_SAME(a_count_in_range, phase_q == slfc_pkg::PH_PAYLOAD, count_q < length_q, "payload count beyond length")
  `SLFC_ASSERT_NEXT(a_badlen_clears, in_xfer && evt_d == slfc_pkg::EV_BADLEN, phase_q == slfc_pkg::PH_SYNC0 && length_q == '0 && crc_q == slfc_pkg::CrcInit, "bad length did not clear frame")

endmodule

// File: dv/sync_length_frame_crc16_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_length_frame_crc16_parser_tb
// Byte-stream test of the sync/length frame parser. Directed frames cover the
// corner cases. Random good, corrupted and broken frames then run under several
// register settings and stall patterns. Every result is checked against an
// in-bench parser with its own crc-16/modbus.
// ----------------------------------------------------------------------------
module sync_length_frame_crc16_parser_tb;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned MaxReports = 10;

  typedef struct packed {
    slfc_pkg::event_e           ev;
    logic                       is_pay;
    logic [slfc_pkg::LenW-1:0]  pos;
    logic [slfc_pkg::ByteW-1:0] cmd;
    logic [slfc_pkg::LenW-1:0]  len;
  } parse_result_t;

  logic clk_i;
  logic rst_ni;

  slfc_in_if  rx_if ();
  slfc_cfg_if cfg_if ();
  slfc_out_if res_if ();

  sync_length_frame_crc16_parser i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .cfg_i  (cfg_if),
    .res_o  (res_if)
  );

  logic [slfc_pkg::ByteW-1:0] byte_q[$];
  parse_result_t              pending_parse_q[$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned rx_queued  = 0;
  int unsigned rx_taken   = 0;
  int unsigned res_seen   = 0;
  int unsigned mismatches = 0;
  int unsigned n_ready    = 0;
  int unsigned n_badlen   = 0;
  int unsigned n_badcrc   = 0;
  int unsigned n_payload  = 0;
  int unsigned cycles     = 0;
  logic        rx_moved;

  // register values as the stimulus side last wrote them
  logic [slfc_pkg::ByteW-1:0] gen_sync_a;
  logic [slfc_pkg::ByteW-1:0] gen_sync_b;
  logic [slfc_pkg::LenW-1:0]  gen_max_len;

  // register values and frame state as the parser holds them
  logic [slfc_pkg::ByteW-1:0] live_sync_a;
  logic [slfc_pkg::ByteW-1:0] live_sync_b;
  logic [slfc_pkg::LenW-1:0]  live_max_len;
  slfc_pkg::phase_e           hunt_phase;
  logic [slfc_pkg::LenW-1:0]  len_acc;
  logic [slfc_pkg::ByteW-1:0] cmd_latch;
  logic [slfc_pkg::LenW-1:0]  pay_idx;
  logic [slfc_pkg::CrcW-1:0]  crc_acc;
  logic [slfc_pkg::CrcW-1:0]  crc_rx;

  // bit-serial form, lsb first
  function automatic logic [slfc_pkg::CrcW-1:0] modbus_crc_byte(
      input logic [slfc_pkg::CrcW-1:0]  acc,
      input logic [slfc_pkg::ByteW-1:0] data);
    logic [slfc_pkg::CrcW-1:0] r;
    logic                      fb;
    r = acc;
    for (int i = 0; i < slfc_pkg::ByteW; i++) begin
      fb = r[0] ^ data[i];
      r  = (r >> 1) ^ (fb ? slfc_pkg::CrcPoly : '0);
    end
    return r;
  endfunction

  function automatic void restart_hunt();
    hunt_phase = slfc_pkg::PH_SYNC0;
    len_acc    = '0;
    cmd_latch  = '0;
    pay_idx    = '0;
    crc_acc    = slfc_pkg::CrcInit;
    crc_rx     = '0;
  endfunction

  function automatic parse_result_t parse_byte(input logic [slfc_pkg::ByteW-1:0] b);
    parse_result_t r;
    r        = '0;
    r.ev     = slfc_pkg::EV_NONE;
    case (hunt_phase)
      slfc_pkg::PH_SYNC0: begin
        if (b == live_sync_a) hunt_phase = slfc_pkg::PH_SYNC1;
      end
      slfc_pkg::PH_SYNC1: begin
        hunt_phase = (b == live_sync_b) ? slfc_pkg::PH_LEN_LO : slfc_pkg::PH_SYNC0;
      end
      slfc_pkg::PH_LEN_LO: begin
        len_acc    = {8'h00, b};
        hunt_phase = slfc_pkg::PH_LEN_HI;
      end
      slfc_pkg::PH_LEN_HI: begin
        len_acc[15:8] = b;
        if (len_acc > live_max_len) begin
          restart_hunt();
          r.ev = slfc_pkg::EV_BADLEN;
        end else begin
          hunt_phase = slfc_pkg::PH_CMD;
        end
      end
      slfc_pkg::PH_CMD: begin
        cmd_latch  = b;
        pay_idx    = '0;
        crc_acc    = modbus_crc_byte(slfc_pkg::CrcInit, b);
        hunt_phase = (len_acc == '0) ? slfc_pkg::PH_CRC_LO : slfc_pkg::PH_PAYLOAD;
      end
      slfc_pkg::PH_PAYLOAD: begin
        r.is_pay = 1'b1;
        r.pos    = pay_idx;
        crc_acc  = modbus_crc_byte(crc_acc, b);
        pay_idx++;
        if (pay_idx == len_acc) hunt_phase = slfc_pkg::PH_CRC_LO;
      end
      slfc_pkg::PH_CRC_LO: begin
        crc_rx     = {8'h00, b};
        hunt_phase = slfc_pkg::PH_CRC_HI;
      end
      default: begin
        crc_rx[15:8] = b;
        if (crc_rx == crc_acc) begin
          hunt_phase = slfc_pkg::PH_SYNC0;
          r.ev       = slfc_pkg::EV_READY;
        end else begin
          restart_hunt();
          r.ev = slfc_pkg::EV_BADCRC;
        end
      end
    endcase
    r.cmd = cmd_latch;
    r.len = len_acc;
    return r;
  endfunction

  function automatic void push_byte(input logic [slfc_pkg::ByteW-1:0] b);
    byte_q.push_back(b);
    rx_queued++;
  endfunction

  // length, command, random payload and crc; flip corrupts the crc
  function automatic void queue_frame_body(input logic [slfc_pkg::LenW-1:0]  len,
                                           input logic [slfc_pkg::ByteW-1:0] cmd,
                                           input logic [slfc_pkg::CrcW-1:0]  flip);
    logic [slfc_pkg::CrcW-1:0]  crc;
    logic [slfc_pkg::ByteW-1:0] d;
    push_byte(len[7:0]);
    push_byte(len[15:8]);
    push_byte(cmd);
    crc = modbus_crc_byte(slfc_pkg::CrcInit, cmd);
    for (int i = 0; i < len; i++) begin
      d   = 8'($urandom_range(255));
      crc = modbus_crc_byte(crc, d);
      push_byte(d);
    end
    crc ^= flip;
    push_byte(crc[7:0]);
    push_byte(crc[15:8]);
  endfunction

  function automatic void queue_frame(input logic [slfc_pkg::LenW-1:0] len,
                                      input logic [slfc_pkg::CrcW-1:0] flip);
    push_byte(gen_sync_a);
    push_byte(gen_sync_b);
    queue_frame_body(len, 8'($urandom_range(255)), flip);
  endfunction

  function automatic void queue_random_traffic(input int unsigned n_bytes);
    int unsigned               stop_at;
    int unsigned               kind;
    int unsigned               cap;
    int unsigned               flen;
    logic [slfc_pkg::CrcW-1:0] flip;
    stop_at = rx_queued + n_bytes;
    cap     = (gen_max_len < 8) ? gen_max_len : 8;
    while (rx_queued < stop_at) begin
      kind = $urandom_range(99);
      flen = $urandom_range(cap);
      if (kind < 68) begin
        queue_frame(slfc_pkg::LenW'(flen), '0);
      end else if (kind < 80) begin
        flip = slfc_pkg::CrcW'(1) << $urandom_range(slfc_pkg::CrcW-1);
        queue_frame(slfc_pkg::LenW'(flen), flip);
      end else if (kind < 88 && gen_max_len != '1) begin
        flen = $urandom_range(1) ? gen_max_len + 1 : $urandom_range(16'hFFFF, gen_max_len + 1);
        push_byte(gen_sync_a);
        push_byte(gen_sync_b);
        push_byte(flen[7:0]);
        push_byte(flen[15:8]);
      end else if (kind < 95) begin
        repeat ($urandom_range(6, 1)) push_byte(8'($urandom_range(255)));
      end else if (kind < 98) begin
        push_byte(gen_sync_a);
        push_byte(gen_sync_b ^ (8'h01 << $urandom_range(7)));
      end else begin
        // cut short after the command: the next frame lands in the payload, or in the crc for a zero length
        push_byte(gen_sync_a);
        push_byte(gen_sync_b);
        push_byte(flen[7:0]);
        push_byte(flen[15:8]);
        push_byte(8'($urandom_range(255)));
      end
    end
  endfunction

  task automatic wait_drained();
    while (rx_taken != rx_queued || res_seen != rx_taken) @(negedge clk_i);
  endtask

  task automatic write_reg(input slfc_pkg::cfg_reg_e idx,
                           input logic [slfc_pkg::CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    case (idx)
      slfc_pkg::REG_SYNC_FIRST:  gen_sync_a  = val[slfc_pkg::ByteW-1:0];
      slfc_pkg::REG_SYNC_SECOND: gen_sync_b  = val[slfc_pkg::ByteW-1:0];
      slfc_pkg::REG_MAX_LEN:     gen_max_len = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic apply_settings(input logic [slfc_pkg::ByteW-1:0] sa,
                                input logic [slfc_pkg::ByteW-1:0] sb,
                                input logic [slfc_pkg::LenW-1:0]  mx);
    wait_drained();
    // upper data bits are junk for the byte-wide registers
    write_reg(slfc_pkg::REG_SYNC_FIRST, {8'($urandom), sa});
    write_reg(slfc_pkg::REG_SYNC_SECOND, {8'($urandom), sb});
    write_reg(slfc_pkg::REG_MAX_LEN, mx);
    write_reg(slfc_pkg::REG_UNUSED, 16'($urandom));
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d of %0d bytes taken",
               cycles, rx_taken, rx_queued);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // byte driver, holds a byte until its transfer
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      rx_if.valid <= 1'b0;
    end else if (!rx_if.valid || rx_moved) begin
      if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= byte_q.pop_front();
      end else begin
        rx_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    parse_result_t want;
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          slfc_pkg::REG_SYNC_FIRST:  live_sync_a  = cfg_if.data[slfc_pkg::ByteW-1:0];
          slfc_pkg::REG_SYNC_SECOND: live_sync_b  = cfg_if.data[slfc_pkg::ByteW-1:0];
          slfc_pkg::REG_MAX_LEN:     live_max_len = cfg_if.data;
          default: ;
        endcase
      end
      rx_moved <= rx_if.valid && rx_if.ready;
      if (rx_if.valid && rx_if.ready) begin
        pending_parse_q.push_back(parse_byte(rx_if.rx_byte));
        rx_taken++;
      end
      if (res_if.valid && res_if.ready) begin
        res_seen++;
        if (pending_parse_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReports) begin
            $display("result %0d arrived with no byte pending: ev=%0d cmd=%02h len=%0d",
                     res_seen, res_if.event_res, res_if.frame_command, res_if.frame_length);
          end
        end else begin
          want = pending_parse_q.pop_front();
          n_ready   += (want.ev == slfc_pkg::EV_READY);
          n_badlen  += (want.ev == slfc_pkg::EV_BADLEN);
          n_badcrc  += (want.ev == slfc_pkg::EV_BADCRC);
          n_payload += want.is_pay;
          if (res_if.event_res !== want.ev || res_if.is_payload !== want.is_pay ||
              res_if.payload_position !== want.pos || res_if.frame_command !== want.cmd ||
              res_if.frame_length !== want.len) begin
            mismatches++;
            if (mismatches <= MaxReports) begin
              $display("result %0d wrong: want ev=%0d pay=%0b pos=%0d cmd=%02h len=%0d",
                       res_seen, want.ev, want.is_pay, want.pos, want.cmd, want.len);
              $display("  got ev=%0d pay=%0b pos=%0d cmd=%02h len=%0d",
                       res_if.event_res, res_if.is_payload, res_if.payload_position,
                       res_if.frame_command, res_if.frame_length);
            end
          end
        end
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    rx_moved      = 1'b0;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = '0;
    cfg_if.valid  = 1'b0;
    cfg_if.index  = slfc_pkg::REG_SYNC_FIRST;
    cfg_if.data   = '0;
    res_if.ready  = 1'b0;
    gen_sync_a    = slfc_pkg::SyncFirstRst;
    gen_sync_b    = slfc_pkg::SyncSecondRst;
    gen_max_len   = slfc_pkg::MaxLenRst;
    live_sync_a   = slfc_pkg::SyncFirstRst;
    live_sync_b   = slfc_pkg::SyncSecondRst;
    live_max_len  = slfc_pkg::MaxLenRst;
    restart_hunt();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // zero length, crc over the command alone
    push_byte(gen_sync_a);
    push_byte(gen_sync_b);
    queue_frame_body(16'd0, 8'h00, '0);
    // one above the length limit
    push_byte(gen_sync_a);
    push_byte(gen_sync_b);
    push_byte(8'h01);
    push_byte(8'h01);
    // repeated first sync byte is not taken as a new start
    push_byte(gen_sync_a);
    push_byte(gen_sync_a);
    push_byte(gen_sync_b);
    // corrupted crc
    push_byte(gen_sync_a);
    push_byte(gen_sync_b);
    queue_frame_body(16'd1, 8'hFF, 16'h8000);
    // leave the header open at the high length byte
    push_byte(gen_sync_a);
    push_byte(gen_sync_b);
    push_byte(8'h05);

    apply_settings(8'h00, 8'hFF, 16'h0000);
    // pending high length byte now meets a zero limit
    push_byte(8'h00);
    // second sync value changes while the parser waits for it
    push_byte(8'h00);
    wait_drained();
    write_reg(slfc_pkg::REG_SYNC_SECOND, 16'h003C);
    push_byte(8'h3C);
    queue_frame_body(16'd0, 8'($urandom_range(255)), '0);
    wait_drained();
    write_reg(slfc_pkg::REG_SYNC_SECOND, 16'hFFFF);
    queue_random_traffic(30);

    apply_settings(8'hFF, 8'h00, 16'hFFFF);
    send_idle_pct = 68;
    queue_frame(16'd257, '0);
    queue_random_traffic(30);

    apply_settings(8'h7E, 8'h7E, 16'd5);
    send_idle_pct  = 0;
    recv_stall_pct = 68;
    queue_random_traffic(30);

    apply_settings(8'($urandom_range(255)), 8'($urandom_range(255)),
                   16'($urandom_range(12)));
    send_idle_pct  = 31;
    recv_stall_pct = 31;
    queue_random_traffic(30);

    wait_drained();
    repeat (4) @(negedge clk_i);
    $display("%0d bytes parsed: %0d frames ready, %0d bad length, %0d bad crc",
             rx_taken, n_ready, n_badlen, n_badcrc);
    $display("%0d payload bytes over five register settings and four stall mixes, %0d errors",
             n_payload, mismatches);
    if (mismatches == 0 && pending_parse_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
